>>> rtl/qsm3_pkg.sv
// Package for the counting quicksort block: the comparison counter width and
// its saturation value. No dependencies.
`default_nettype none
package qsm3_pkg;
  localparam int CountWidth = 16;
  localparam logic [CountWidth-1:0] CountMax = '1;
endpackage
`default_nettype wire

>>> rtl/quicksort_median_of_three_counted.sv
// Counting quicksort top level: key memory, range stack memory and the
// sort sequencer. Depends on qsm3_pkg.
//
// Keys load one per accepted item (start high, busy low), one per cycle
// while start stays high. Keys beyond MAX_KEYS are dropped, and a final_key
// on a dropped key still sorts the stored set. The item with final_key set
// starts the sort; busy stays high through the sort and the output phase.
// The sort is quicksort with a median-of-three pivot and a Lomuto partition
// over a single-port key memory with registered reads. A comparison steps
// through S_CMP, S_CMPA and S_CMPB, a swap through S_SWA, S_SWB, S_SWW and
// S_SWX, and each partition step adds a pass through S_SCAN. Each range
// adds stack handling and a final swap on top of its median step (two or
// four comparisons, plus a swap when the pivot moves). Many equal keys
// make the partitions uneven. Results come in ascending order, strobe
// high for one cycle each and low between; the receiver cannot stall them.
// The last result carries last_result and the saturating compare_total.
`default_nettype none
module quicksort_median_of_three_counted
  import qsm3_pkg::*;
#(
  parameter int MAX_KEYS  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [31:0]    key_value,
  input  wire logic                  final_key,
  output logic                       strobe,
  output logic signed [31:0]         sorted_value,
  output logic [CountWidth-1:0]      compare_total,
  output logic                       last_result
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = AW + 1;
  localparam int MW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam logic [CW-1:0] KeysMax = CW'(MAX_KEYS);

  localparam logic [4:0] S_IDLE = 5'd0, S_POP = 5'd1, S_POPW = 5'd2,
    S_RNG = 5'd3, S_CMP = 5'd4, S_CMPA = 5'd5, S_CMPB = 5'd6,
    S_SWA = 5'd7, S_SWB = 5'd8, S_SWW = 5'd9, S_SWX = 5'd10,
    S_SCAN = 5'd11, S_PUSH1 = 5'd12, S_PUSH2 = 5'd13, S_DONE = 5'd14,
    S_OUT = 5'd15, S_OUTW = 5'd16;

  // compare/swap return codes
  localparam logic [2:0] R_C1 = 3'd0, R_C2 = 3'd1, R_C3 = 3'd2, R_C4 = 3'd3,
    R_PJ = 3'd4, R_PSW = 3'd5, R_FIN = 3'd6, R_MED = 3'd7;

  logic [KEY_WIDTH-1:0] kmem [MAX_KEYS];
  logic [2*AW-1:0]      smem [MAX_KEYS];

  logic [4:0]  state;
  logic [2:0]  ret;
  logic [CW-1:0] count, depth, outk, count_inc;
  logic [AW-1:0] s, e, m, j, slot, ia, ib;
  logic [KEY_WIDTH-1:0] ka, rd;
  logic [2*AW-1:0] srd;
  logic c1, c3, lt, push_hi, push_lo, out_last;
  logic [CountWidth-1:0] cmpc;

  logic          kwe;
  logic [AW-1:0] kaddr;
  logic [KEY_WIDTH-1:0] kwd;
  logic          swe;
  logic [AW-1:0] saddr;
  logic [2*AW-1:0] swd;

  logic [KEY_WIDTH-1:0] kin;
  logic [31:0] out_word;
  logic signed [KEY_WIDTH-1:0] sa, sb;
  logic [AW:0] mid_sum;

  always_comb begin
    kin = '0;
    kin[MW-1:0] = key_value[MW-1:0];
  end

  always_comb begin
    out_word = '0;
    out_word[MW-1:0] = rd[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (kwe) kmem[kaddr] <= kwd;
    rd <= kmem[kaddr];
  end
  always_ff @(posedge clk) begin
    if (swe) smem[saddr] <= swd;
    srd <= smem[saddr];
  end

  assign sa = $signed(ka);
  assign sb = $signed(rd);
  assign lt = (sa < sb);

  assign busy = (state != S_IDLE);

  assign mid_sum = {1'b0, s} + {1'b0, e};
  assign count_inc = (count < KeysMax) ? count + 1'b1 : count;
  assign push_hi = (CW'(slot) + 1'b1 < CW'(e)) && (depth < KeysMax);
  assign push_lo = (CW'(slot) > CW'(s) + 1'b1) && (depth < KeysMax);
  assign out_last = (outk + 1'b1 == count);

  always_comb begin
    kwe = 1'b0;
    kaddr = ia;
    kwd = rd;
    swe = 1'b0;
    saddr = depth[AW-1:0];
    swd = {AW'(slot + 1'b1), e};
    case (state)
      S_IDLE: begin
        kaddr = count[AW-1:0];
        kwd = kin;
        kwe = start && (count < KeysMax);
      end
      S_POP: saddr = AW'(depth - 1'b1);
      S_CMPA, S_SWB: kaddr = ib;
      S_SWW: kwe = 1'b1;
      S_SWX: begin
        kaddr = ib;
        kwe = 1'b1;
        kwd = ka;
      end
      S_PUSH1: swe = push_hi;
      S_PUSH2: begin
        swe = push_lo;
        swd = {s, AW'(slot - 1'b1)};
      end
      S_OUT: kaddr = outk[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; depth <= '0; cmpc <= '0; outk <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            count <= count_inc;
            if (final_key) begin
              cmpc <= '0;
              depth <= '0;
              s <= '0;
              e <= AW'(count_inc - 1'b1);
              state <= (count_inc >= CW'(2)) ? S_RNG : S_DONE;
            end
          end
        end
        S_POP: begin
          if (depth == '0) state <= S_DONE;
          else begin depth <= depth - 1'b1; state <= S_POPW; end
        end
        S_POPW: begin
          s <= srd[2*AW-1:AW]; e <= srd[AW-1:0]; state <= S_RNG;
        end
        S_RNG: begin
          if (e <= s || CW'(e) >= count) state <= S_POP;
          else begin
            m <= mid_sum[AW:1];
            ia <= s; ib <= mid_sum[AW:1]; ret <= R_C1; state <= S_CMP;
          end
        end
        S_CMP: state <= S_CMPA;
        S_CMPA: begin ka <= rd; state <= S_CMPB; end
        S_CMPB: begin
          if (cmpc != CountMax) cmpc <= cmpc + 1'b1;
          case (ret)
            R_C1: begin c1 <= lt; ib <= e; ret <= R_C2; state <= S_CMP; end
            R_C2: begin
              if (c1 != lt) begin
                ret <= R_MED; state <= S_SWA;
              end else begin
                ia <= m; ib <= s; ret <= R_C3; state <= S_CMP;
              end
            end
            R_C3: begin c3 <= lt; ib <= e; ret <= R_C4; state <= S_CMP; end
            R_C4: begin
              if (c3 != lt) begin
                ret <= R_MED; state <= S_SWA;
              end else begin
                slot <= s; j <= s; state <= S_SCAN;
              end
            end
            R_PJ: begin
              if (lt) begin
                ia <= slot; ib <= j; ret <= R_PSW; state <= S_SWA;
              end else begin
                j <= j + 1'b1; state <= S_SCAN;
              end
            end
            default: state <= S_SCAN;
          endcase
        end
        S_SWA: state <= S_SWB;
        S_SWB: begin ka <= rd; state <= S_SWW; end
        S_SWW: state <= S_SWX;
        S_SWX: begin
          case (ret)
            R_MED: begin slot <= s; j <= s; state <= S_SCAN; end
            R_PSW: begin slot <= slot + 1'b1; j <= j + 1'b1; state <= S_SCAN; end
            default: state <= S_PUSH1;
          endcase
        end
        S_SCAN: begin
          ib <= e;
          if (j == e) begin
            ia <= slot; ret <= R_FIN; state <= S_SWA;
          end else begin
            ia <= j; ret <= R_PJ; state <= S_CMP;
          end
        end
        S_PUSH1: begin
          if (push_hi) depth <= depth + 1'b1;
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_lo) depth <= depth + 1'b1;
          state <= S_POP;
        end
        S_DONE: begin outk <= '0; state <= S_OUT; end
        S_OUT: begin
          if (outk >= count) begin
            count <= '0; depth <= '0; cmpc <= '0; state <= S_IDLE;
          end else state <= S_OUTW;
        end
        S_OUTW: begin
          outk <= outk + 1'b1;
          state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last_result <= 1'b0;
      compare_total <= '0;
      sorted_value <= '0;
    end else begin
      strobe <= (state == S_OUTW);
      last_result <= (state == S_OUTW) && out_last;
      compare_total <= ((state == S_OUTW) && out_last) ? cmpc : '0;
      sorted_value <= (state == S_OUTW) ? out_word : '0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= KeysMax) else $error("key count overflow");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= KeysMax) else $error("range stack overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside run");
  a_last: assert property (@(posedge clk) disable iff (rst)
    last_result |-> strobe) else $error("last without strobe");
endmodule
`default_nettype wire
